// File: rtl/mat_pkg.sv
// ----------------------------------------------------------------------------
// mat_pkg
// Shared types and constants of the MIPS joint-TLB address translation block.
// ----------------------------------------------------------------------------
package mat_pkg;

    localparam logic [2:0] FC_NONE = 3'd0;
    localparam logic [2:0] FC_ADEL = 3'd1;
    localparam logic [2:0] FC_ADES = 3'd2;
    localparam logic [2:0] FC_TLBL = 3'd3;
    localparam logic [2:0] FC_TLBS = 3'd4;
    localparam logic [2:0] FC_MOD  = 3'd5;

    localparam logic [1:0] CFG_ASID      = 2'd0;
    localparam logic [1:0] CFG_USR_MODE  = 2'd1;
    localparam logic [1:0] CFG_ERR_LEVEL = 2'd2;
    localparam logic [1:0] CFG_PT_BASE   = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 136;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLASS,
        S_SEARCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        we;
        logic [3:0]  index;
        logic [18:0] vpn_pair;
        logic [7:0]  asid;
        logic        global_bit;
        logic [31:0] page_end;
        logic [19:0] frame_even;
        logic [19:0] frame_odd;
        logic [3:0]  flags;
    } t_entry_wr;

    typedef struct packed {
        logic        live;
        logic        hit;
        logic        valid;
        logic        dirty;
        logic [19:0] frame;
    } t_probe;

    typedef struct packed {
        logic [2:0]  fault_code;
        logic [31:0] physical_address;
        logic        writable;
        logic        refill;
        logic [31:0] bad_vaddr;
        logic [31:0] context_value;
        logic [31:0] entry_hi_value;
    } t_result;

endpackage

// File: rtl/mat_cell.sv
// ----------------------------------------------------------------------------
// mat_cell
// One TLB slot: holds an entry and passes the lookup probe to the next slot.
// ----------------------------------------------------------------------------
module mat_cell
    import mat_pkg::*;
#(
    parameter int CELL_ID = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry_wr   i_wr,
    input  logic [31:0] i_va,
    input  logic [7:0]  i_asid,
    input  t_probe      i_probe,
    output t_probe      o_probe
);

    logic        r_valid;
    logic [18:0] r_vpn_pair;
    logic [7:0]  r_asid;
    logic        r_global;
    logic [31:0] r_page_end;
    logic [19:0] r_frame_even;
    logic [19:0] r_frame_odd;
    logic [3:0]  r_flags;
    t_probe      r_probe;
    t_probe      n_probe;
    logic        w_sel;
    logic        w_match;

    assign w_sel = i_wr.we && (int'(i_wr.index) == CELL_ID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_vpn_pair   <= i_wr.vpn_pair;
            r_asid       <= i_wr.asid;
            r_global     <= i_wr.global_bit;
            r_page_end   <= i_wr.page_end;
            r_frame_even <= i_wr.frame_even;
            r_frame_odd  <= i_wr.frame_odd;
            r_flags      <= i_wr.flags;
        end
    end

    assign w_match = r_valid && (r_global || (r_asid == i_asid)) &&
                     (r_vpn_pair == i_va[31:13]) && (i_va < r_page_end);

    always_comb begin
        n_probe = i_probe;
        if (i_probe.live && !i_probe.hit && w_match) begin
            n_probe.hit   = 1'b1;
            n_probe.valid = i_va[12] ? r_flags[2] : r_flags[0];
            n_probe.dirty = i_va[12] ? r_flags[3] : r_flags[1];
            n_probe.frame = i_va[12] ? r_frame_odd : r_frame_even;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe.hit   <= n_probe.hit;
        r_probe.valid <= n_probe.valid;
        r_probe.dirty <= n_probe.dirty;
        r_probe.frame <= n_probe.frame;
        if (!i_rst_n) begin
            r_probe.live <= 1'b0;
        end else begin
            r_probe.live <= n_probe.live;
        end
    end

    assign o_probe = r_probe;

endmodule

// File: rtl/mips_address_translate_tlb.sv
// ----------------------------------------------------------------------------
// mips_address_translate_tlb
// MIPS32 joint-TLB address translation with a chain of TLB slot cells.
//
// Channel     Direction  Content
// s_axis      in         tuser: mode; tdata: vaddr, is_store, entry_index,
//                        entry_vpn_pair, entry_asid, entry_global,
//                        entry_page_end, entry_frame_even, entry_frame_odd,
//                        entry_flags
// m_axis      out        tdata: fault_code, physical_address, writable,
//                        refill, bad_vaddr, context_value, entry_hi_value
// cfg         in         write enable, register index, write data
//
// One request at a time. Entry writes, unmapped accesses and address errors
// pass through S_CLASS and the result register into the output register; a TLB
// lookup also walks the probe through the slot cells in S_SEARCH, one slot cell
// per cycle, lowest slot first. The next request is taken in the cycle after the output loads.
// Reset clears all slots at once. A new request is taken while a result waits
// in the output register; a stalled result holds the next one in S_DONE.
// ----------------------------------------------------------------------------
module mips_address_translate_tlb
    import mat_pkg::*;
#(
    parameter int TLB_ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // vaddr, is_store, entry_index, entry_vpn_pair, entry_asid, entry_global,
    // entry_page_end, entry_frame_even, entry_frame_odd, entry_flags, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // mode
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // fault_code, physical_address, writable, refill, bad_vaddr,
    // context_value, entry_hi_value, zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_state      r_state;
    t_state      n_state;
    logic [7:0]  r_cur_asid;
    logic        r_usr_mode;
    logic        r_error_level;
    logic [8:0]  r_pt_base;
    logic [31:0] r_va;
    logic        r_store;
    logic        r_mode;
    t_result     r_res;
    t_result     n_res;
    t_result     r_out;
    logic        r_out_valid;
    logic        w_accept;
    logic        w_out_load;
    logic        w_launch;
    logic        w_adr_err;
    logic        w_needs_tlb;
    t_entry_wr   w_wr;
    t_probe      w_chain [TLB_ENTRIES+1];
    t_probe      w_last;
    t_result     w_fault;
    t_result     w_direct;
    t_result     w_tlb;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load      = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_asid    <= '0;
            r_usr_mode    <= 1'b0;
            r_error_level <= 1'b1;
            r_pt_base     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ASID:      r_cur_asid    <= i_cfg_wdata[7:0];
                CFG_USR_MODE:  r_usr_mode    <= i_cfg_wdata[0];
                CFG_ERR_LEVEL: r_error_level <= i_cfg_wdata[0];
                CFG_PT_BASE:   r_pt_base     <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_va    <= i_s_axis_tdata[31:0];
            r_store <= i_s_axis_tdata[32];
            r_mode  <= i_s_axis_tuser;
        end
    end

    always_comb begin
        w_wr.we         = w_accept && i_s_axis_tuser;
        w_wr.index      = i_s_axis_tdata[36:33];
        w_wr.vpn_pair   = i_s_axis_tdata[55:37];
        w_wr.asid       = i_s_axis_tdata[63:56];
        w_wr.global_bit = i_s_axis_tdata[64];
        w_wr.page_end   = i_s_axis_tdata[96:65];
        w_wr.frame_even = i_s_axis_tdata[116:97];
        w_wr.frame_odd  = i_s_axis_tdata[136:117];
        w_wr.flags      = i_s_axis_tdata[140:137];
    end

    always_comb begin
        w_chain[0]       = '0;
        w_chain[0].live  = w_launch;
    end

    for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
        mat_cell #(
            .CELL_ID (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_va    (r_va),
            .i_asid  (r_cur_asid),
            .i_probe (w_chain[g]),
            .o_probe (w_chain[g+1])
        );
    end

    assign w_last = w_chain[TLB_ENTRIES];

    assign w_adr_err   = r_usr_mode && r_va[31];
    assign w_needs_tlb = !w_adr_err &&
                         ((!r_va[31] && !r_error_level) || (r_va[31:30] == 2'b11));

    always_comb begin
        w_fault                  = '0;
        w_fault.bad_vaddr        = r_va;
        w_fault.context_value    = {r_pt_base, r_va[30:12], 4'b0000};
        w_fault.entry_hi_value   = {r_va[31:12], 4'b0000, r_cur_asid};

        w_direct                 = '0;
        if (w_adr_err) begin
            w_direct             = w_fault;
            w_direct.fault_code  = r_store ? FC_ADES : FC_ADEL;
        end else begin
            w_direct.fault_code       = FC_NONE;
            w_direct.physical_address = r_va[31] ? {3'b000, r_va[28:0]} : r_va;
            w_direct.writable         = 1'b1;
        end

        w_tlb                    = w_fault;
        if (!w_last.hit) begin
            w_tlb.fault_code     = r_store ? FC_TLBS : FC_TLBL;
            w_tlb.refill         = 1'b1;
        end else if (!w_last.valid) begin
            w_tlb.fault_code     = r_store ? FC_TLBS : FC_TLBL;
        end else if (r_store && !w_last.dirty) begin
            w_tlb.fault_code     = FC_MOD;
        end else begin
            w_tlb                  = '0;
            w_tlb.fault_code       = FC_NONE;
            w_tlb.physical_address = {w_last.frame, r_va[11:0]};
            w_tlb.writable         = w_last.dirty;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        w_launch = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (r_mode) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else if (w_needs_tlb) begin
                    w_launch = 1'b1;
                    n_state  = S_SEARCH;
                end else begin
                    n_res   = w_direct;
                    n_state = S_DONE;
                end
            end
            S_SEARCH: begin
                if (w_last.live) begin
                    n_res   = w_tlb;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.entry_hi_value, r_out.context_value,
                              r_out.bad_vaddr, r_out.refill, r_out.writable,
                              r_out.physical_address, r_out.fault_code};

endmodule

// File: rtl/mat_checker.sv
// ----------------------------------------------------------------------------
// mat_checker
// Port-level checks of the TLB translation block, bound to its top level.
// ----------------------------------------------------------------------------
module mat_checker
    import mat_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2:0] <= FC_MOD))
        else $error("fault code out of range");

    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[2:0] != FC_NONE) |->
            (o_m_axis_tdata[35:3] == '0))
        else $error("fault carries an address");

    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[2:0] == FC_NONE) |->
            (o_m_axis_tdata[132:36] == '0))
        else $error("fault fields set without a fault");

endmodule

bind mips_address_translate_tlb mat_checker u_mat_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
